### rtl/core/saes32_pkg.sv
// Package for the scalar AES32 round-slice core: command codes, GF(2^8) helpers
// and the forward and inverse S-box tables, built at elaboration.
// Used by saes32_datapath and scalar_aes32_byte_round_core.
package saes32_pkg;

    typedef logic [1:0]            t_cmd;
    typedef logic [1:0]            t_bsel;
    typedef logic [31:0]           t_word;
    typedef logic [7:0]            t_byte;
    typedef logic [255:0][7:0]     t_sbox_tbl;

    localparam t_cmd CMD_ENC_FINAL  = 2'd0;
    localparam t_cmd CMD_ENC_MIDDLE = 2'd1;
    localparam t_cmd CMD_DEC_FINAL  = 2'd2;
    localparam t_cmd CMD_DEC_MIDDLE = 2'd3;

    localparam t_byte AES_POLY_LOW = 8'h1b;
    localparam t_byte AFFINE_CONST = 8'h63;

    // Multiply by x modulo x^8+x^4+x^3+x+1.
    function automatic t_byte f_xtime(input t_byte a);
        f_xtime = {a[6:0], 1'b0} ^ (a[7] ? AES_POLY_LOW : 8'h00);
    endfunction

    // Multiply by a 4-bit constant: four shift-and-add steps.
    function automatic t_byte f_gf_mul4(input t_byte a, input logic [3:0] k);
        t_byte acc;
        t_byte x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 4; i++) begin
            if (k[i]) begin
                acc = acc ^ x;
            end
            x = f_xtime(x);
        end
        f_gf_mul4 = acc;
    endfunction

    function automatic t_byte f_rotl1(input t_byte b);
        f_rotl1 = {b[6:0], b[7]};
    endfunction

    // Forward S-box from the multiplicative inverse (through log and antilog
    // tables with generator 3) followed by the affine map. Zero maps to zero
    // before the affine step.
    function automatic t_sbox_tbl f_build_fwd();
        t_byte     exp_t [256];
        t_byte     log_t [256];
        t_sbox_tbl tbl;
        t_byte     p;
        t_byte     b;
        t_byte     r;
        int        e;
        p = 8'h01;
        for (int i = 0; i < 256; i++) begin
            exp_t[i] = 8'h00;
            log_t[i] = 8'h00;
        end
        for (int i = 0; i < 255; i++) begin
            exp_t[i] = p;
            log_t[p] = i[7:0];
            p = p ^ f_xtime(p);
        end
        for (int x = 0; x < 256; x++) begin
            if (x == 0) begin
                b = 8'h00;
            end else begin
                e = (255 - int'(log_t[x])) % 255;
                b = exp_t[e];
            end
            r = b;
            for (int k = 0; k < 4; k++) begin
                r = f_rotl1(r);
                b = b ^ r;
            end
            tbl[x] = b ^ AFFINE_CONST;
        end
        f_build_fwd = tbl;
    endfunction

    function automatic t_sbox_tbl f_build_inv(input t_sbox_tbl fwd);
        t_sbox_tbl tbl;
        tbl = '0;
        for (int x = 0; x < 256; x++) begin
            tbl[fwd[x]] = x[7:0];
        end
        f_build_inv = tbl;
    endfunction

    localparam t_sbox_tbl SBOX_FWD = f_build_fwd();
    localparam t_sbox_tbl SBOX_INV = f_build_inv(SBOX_FWD);

endpackage

### rtl/core/saes32_datapath.sv
// Combinational round slice: byte select, S-box, MixColumns column,
// rotation and XOR with rs1. Depends on saes32_pkg.
module saes32_datapath (
    input  saes32_pkg::t_cmd  i_cmd,
    input  saes32_pkg::t_bsel i_byte_select,
    input  saes32_pkg::t_word i_rs1_word,
    input  saes32_pkg::t_word i_rs2_word,
    output saes32_pkg::t_word o_result_word
);
    import saes32_pkg::*;

    t_byte sel_byte;
    t_byte sbox_out;
    t_word raw_word;
    t_word rot_word;

    always_comb begin
        case (i_byte_select)
            2'd0:    sel_byte = i_rs2_word[7:0];
            2'd1:    sel_byte = i_rs2_word[15:8];
            2'd2:    sel_byte = i_rs2_word[23:16];
            default: sel_byte = i_rs2_word[31:24];
        endcase
    end

    // Bit 1 of the command selects the decrypt direction.
    assign sbox_out = i_cmd[1] ? SBOX_INV[sel_byte] : SBOX_FWD[sel_byte];

    always_comb begin
        unique case (i_cmd)
            CMD_ENC_MIDDLE: raw_word = {f_gf_mul4(sbox_out, 4'h3), sbox_out,
                                        sbox_out, f_gf_mul4(sbox_out, 4'h2)};
            CMD_DEC_MIDDLE: raw_word = {f_gf_mul4(sbox_out, 4'hb),
                                        f_gf_mul4(sbox_out, 4'hd),
                                        f_gf_mul4(sbox_out, 4'h9),
                                        f_gf_mul4(sbox_out, 4'he)};
            CMD_ENC_FINAL, CMD_DEC_FINAL: raw_word = {24'h000000, sbox_out};
            default:        raw_word = {24'h000000, sbox_out};
        endcase
    end

    always_comb begin
        case (i_byte_select)
            2'd0:    rot_word = raw_word;
            2'd1:    rot_word = {raw_word[23:0], raw_word[31:24]};
            2'd2:    rot_word = {raw_word[15:0], raw_word[31:16]};
            default: rot_word = {raw_word[7:0],  raw_word[31:8]};
        endcase
    end

    assign o_result_word = i_rs1_word ^ rot_word;

endmodule

### rtl/core/scalar_aes32_byte_round_core.sv
// Scalar AES32 round-slice core: aes32esi, aes32esmi, aes32dsi, aes32dsmi.
// A start transfer passes through the input register, then the result register, to
// o_done. Throughput: one command per cycle; busy is always low.
// Reset (synchronous, active low) clears the valid flags; data is unaffected.
// Results are shown for one cycle and the receiver cannot stall them.
// Depends on saes32_pkg and saes32_datapath.
module scalar_aes32_byte_round_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  saes32_pkg::t_cmd  i_cmd,
    input  saes32_pkg::t_bsel i_byte_select,
    input  saes32_pkg::t_word i_rs1_word,
    input  saes32_pkg::t_word i_rs2_word,
    output logic              o_done,
    output saes32_pkg::t_word o_result_word
);
    import saes32_pkg::*;

    logic  r_in_valid;
    t_cmd  r_cmd;
    t_bsel r_byte_select;
    t_word r_rs1_word;
    t_word r_rs2_word;
    logic  r_done;
    t_word r_result_word;
    t_word n_result_word;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_done     <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd         <= i_cmd;
            r_byte_select <= i_byte_select;
            r_rs1_word    <= i_rs1_word;
            r_rs2_word    <= i_rs2_word;
        end
        if (r_in_valid) begin
            r_result_word <= n_result_word;
        end
    end

    saes32_datapath u_datapath (
        .i_cmd         (r_cmd),
        .i_byte_select (r_byte_select),
        .i_rs1_word    (r_rs1_word),
        .i_rs2_word    (r_rs2_word),
        .o_result_word (n_result_word)
    );

    assign o_done        = r_done;
    assign o_result_word = r_result_word;

endmodule

### bench/tb_scalar_aes32_byte_round_core.sv
// Self-checking bench for scalar_aes32_byte_round_core. It covers all four AES32 round-slice
// commands, each checked against a local GF(2^8) and S-box model of the instructions.
// Depends on saes32_pkg for the port types and command codes.
module tb_scalar_aes32_byte_round_core;
    import saes32_pkg::*;

    localparam int   QUIET_LIMIT = 1000;
    localparam int   DRAIN_CYCLES = 4;
    localparam int   REPORT_LIMIT = 10;
    localparam t_byte MIX_X2 = 8'h02;
    localparam t_byte MIX_X3 = 8'h03;
    localparam t_byte MIX_X9 = 8'h09;
    localparam t_byte MIX_XB = 8'h0b;
    localparam t_byte MIX_XD = 8'h0d;
    localparam t_byte MIX_XE = 8'h0e;
    localparam t_byte INV_AFFINE_CONST = 8'h05;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_cmd  i_cmd = CMD_ENC_FINAL;
    t_bsel i_byte_select = '0;
    t_word i_rs1_word = '0;
    t_word i_rs2_word = '0;
    logic  o_done;
    t_word o_result_word;

    t_word pending_words[$];
    int    mismatches = 0;
    int    quiet_cycles = 0;
    int    start_idle_pct = 0;

    scalar_aes32_byte_round_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_byte_select (i_byte_select),
        .i_rs1_word    (i_rs1_word),
        .i_rs2_word    (i_rs2_word),
        .o_done        (o_done),
        .o_result_word (o_result_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_byte gf_mult(input t_byte a, input t_byte b);
        t_byte acc;
        t_byte x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // Raising to the power 254 gives the field inverse, and zero stays zero.
    function automatic t_byte gf_recip(input t_byte a);
        t_byte r;
        r = 8'h01;
        for (int i = 0; i < 254; i++) begin
            r = gf_mult(r, a);
        end
        return r;
    endfunction

    function automatic t_byte rot_byte(input t_byte v, input int k);
        t_byte r;
        r = v;
        for (int i = 0; i < k; i++) begin
            r = {r[6:0], r[7]};
        end
        return r;
    endfunction

    function automatic t_byte sub_byte_fwd(input t_byte x);
        t_byte b;
        b = gf_recip(x);
        return b ^ rot_byte(b, 1) ^ rot_byte(b, 2) ^ rot_byte(b, 3) ^ rot_byte(b, 4)
            ^ 8'h63;
    endfunction

    function automatic t_byte sub_byte_inv(input t_byte y);
        return gf_recip(rot_byte(y, 1) ^ rot_byte(y, 3) ^ rot_byte(y, 6) ^ INV_AFFINE_CONST);
    endfunction

    function automatic t_word predict_round_word(input t_cmd cmd, input t_bsel bsel,
                                                 input t_word rs1, input t_word rs2);
        logic  decrypt;
        logic  middle;
        t_byte sel;
        t_byte so;
        t_word col;
        decrypt = (cmd == CMD_DEC_FINAL) || (cmd == CMD_DEC_MIDDLE);
        middle  = (cmd == CMD_ENC_MIDDLE) || (cmd == CMD_DEC_MIDDLE);
        sel     = rs2[8*bsel +: 8];
        so      = decrypt ? sub_byte_inv(sel) : sub_byte_fwd(sel);
        if (!middle) begin
            col = {24'h0, so};
        end else if (decrypt) begin
            col = {gf_mult(so, MIX_XB), gf_mult(so, MIX_XD), gf_mult(so, MIX_X9),
                   gf_mult(so, MIX_XE)};
        end else begin
            col = {gf_mult(so, MIX_X3), so, so, gf_mult(so, MIX_X2)};
        end
        for (int i = 0; i < bsel; i++) begin
            col = {col[23:0], col[31:24]};
        end
        return rs1 ^ col;
    endfunction

    // Called just after a rising edge; returns at the edge that accepts the transfer.
    task automatic send_instr(input t_cmd cmd, input t_bsel bsel,
                              input t_word rs1, input t_word rs2);
        while ($urandom_range(99) < start_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_byte_select <= bsel;
        i_rs1_word    <= rs1;
        i_rs2_word    <= rs2;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_words.push_back(predict_round_word(cmd, bsel, rs1, rs2));
    endtask

    task automatic send_random_instrs(input int count, input int idle_pct);
        t_bsel bsel;
        t_word rs2;
        start_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            bsel = t_bsel'($urandom_range(3));
            rs2  = $urandom;
            // A cleared selected byte exercises the zero-inverse case now and then.
            if ($urandom_range(7) == 0) begin
                rs2[8*bsel +: 8] = 8'h00;
            end
            send_instr(t_cmd'($urandom_range(3)), bsel, $urandom, rs2);
        end
    endtask

    // Every command at every byte position with a zero source, then each command at one position with all-ones sources.
    task automatic test_all_commands_directed();
        t_cmd cmds[4];
        cmds = '{CMD_ENC_FINAL, CMD_ENC_MIDDLE, CMD_DEC_FINAL, CMD_DEC_MIDDLE};
        start_idle_pct = 0;
        foreach (cmds[c]) begin
            for (int b = 0; b < 4; b++) begin
                send_instr(cmds[c], t_bsel'(b), 32'h0000_0000, 32'h0000_0000);
            end
        end
        foreach (cmds[c]) begin
            send_instr(cmds[c], t_bsel'(c), 32'hffff_ffff, 32'hffff_ffff);
        end
    endtask

    task automatic test_random_back_to_back();
        send_random_instrs(190, 0);
    endtask

    task automatic test_random_sparse_start();
        send_random_instrs(180, 58);
    endtask

    task automatic test_random_moderate_idle();
        send_random_instrs(180, 31);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Unexpected result transfer: result_word=%h", o_result_word);
                end
            end else begin
                if (o_result_word !== pending_words[0]) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("result_word mismatch: expected %h, got %h",
                                 pending_words[0], o_result_word);
                    end
                end
                void'(pending_words.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_all_commands_directed();
        test_random_back_to_back();
        test_random_sparse_start();
        test_random_moderate_idle();
        start <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
